>>> rtl/apms_pkg.sv
`default_nettype none

package apms_pkg;

  // Fixed field widths
  localparam int SCORE_W    = 5;
  localparam int SYM_W      = 8;
  localparam int CELL_LIMIT = 16;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  // Register index, taken from paddr[4:3]
  typedef enum logic [1:0] {
    REG_PAT_LO   = 2'd0,
    REG_PAT_HI   = 2'd1,
    REG_PAT_LEN  = 2'd2,
    REG_DIST_LIM = 2'd3
  } reg_idx_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_HOLD = 3'b100
  } state_e;

endpackage

`default_nettype wire

>>> rtl/approx_pattern_match_stream_core.sv
// Input words are taken one at a time: in_stall_o stays high from an accepted word until
// its result is loaded into the output register. The update wavefront
// steps through the cell row one cell per cycle. A finished output word may wait in
// the output register while the next input word is taken.
// Reset: column to prefix lengths with zero starts, position zero, pattern length 1,
// distance limit 0, pattern bytes zero.
`default_nettype none

module approx_pattern_match_stream_core #(
  parameter int PATTERN_MAX   = 16,
  parameter int POSITION_BITS = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [apms_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [apms_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [apms_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                   pready,
  // Input channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [7:0]                        text_symbol_i,
  input  wire logic                              text_restart_i,
  // Output channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [31:0]                            match_start_o,
  output logic [31:0]                            match_end_o,
  output logic [4:0]                             edit_distance_o
);

  localparam int Cap  = (PATTERN_MAX < apms_pkg::CELL_LIMIT) ? PATTERN_MAX
                                                             : apms_pkg::CELL_LIMIT;
  localparam int IdxW = (Cap > 1) ? $clog2(Cap) : 1;
  localparam int SW   = apms_pkg::SCORE_W;

  // Configuration registers
  logic [63:0]   pat_lo_q, pat_hi_q;
  logic [SW-1:0] pat_len_q, dist_lim_q;
  logic          cfg_we;
  apms_pkg::reg_idx_e cfg_idx;

  assign cfg_we = psel && penable && pwrite;
  assign cfg_idx = apms_pkg::reg_idx_e'(paddr[4:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q   <= '0;
      pat_hi_q   <= '0;
      pat_len_q  <= SW'(1);
      dist_lim_q <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        apms_pkg::REG_PAT_LO:   pat_lo_q   <= pwdata;
        apms_pkg::REG_PAT_HI:   pat_hi_q   <= pwdata;
        apms_pkg::REG_PAT_LEN:  pat_len_q  <= pwdata[SW-1:0];
        apms_pkg::REG_DIST_LIM: dist_lim_q <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      apms_pkg::REG_PAT_LO:   prdata = pat_lo_q;
      apms_pkg::REG_PAT_HI:   prdata = pat_hi_q;
      apms_pkg::REG_PAT_LEN:  prdata = {{(64-SW){1'b0}}, pat_len_q};
      apms_pkg::REG_DIST_LIM: prdata = {{(64-SW){1'b0}}, dist_lim_q};
      default:                prdata = '0;
    endcase
  end

  // Sequencer and front registers
  apms_pkg::state_e state_q, state_d;
  logic                     fire0_q;
  logic [7:0]               sym_q;
  logic [POSITION_BITS-1:0] pos_q;
  logic [POSITION_BITS-1:0] base_q;
  logic [POSITION_BITS-1:0] base_w, new_pos_w;
  logic                     in_accept, out_free, done_w, load_w;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != apms_pkg::S_IDLE);
  assign out_free   = !out_valid_o || !out_stall_i;

  // Restart the count on new text, saturate at all ones
  assign base_w    = text_restart_i ? '0 : pos_q;
  assign new_pos_w = (&base_w) ? base_w : base_w + POSITION_BITS'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      fire0_q <= 1'b0;
    end else begin
      fire0_q <= in_accept;
      if (in_accept) begin
        pos_q <= new_pos_w;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sym_q  <= text_symbol_i;
      base_q <= base_w;
    end
  end

  // Cell row
  logic [Cap-1:0]           fire_w;
  logic [SW-1:0]            score_w [Cap];
  logic [POSITION_BITS-1:0] start_w [Cap];
  logic [SW-1:0]            dscore_w [Cap];
  logic [POSITION_BITS-1:0] dstart_w [Cap];
  logic                     init_w;

  assign init_w = in_accept && text_restart_i;

  for (genvar j = 0; j < Cap; j++) begin : g_cell
    logic [7:0]               pat_byte;
    logic                     fire_in;
    logic [SW-1:0]            lscore_in, dscore_in;
    logic [POSITION_BITS-1:0] lstart_in, dstart_in;

    if (j < 8) begin : g_lo
      assign pat_byte = pat_lo_q[8*j +: 8];
    end else begin : g_hi
      assign pat_byte = pat_hi_q[8*(j-8) +: 8];
    end

    if (j == 0) begin : g_head
      assign fire_in   = fire0_q;
      assign lscore_in = '0;
      assign lstart_in = pos_q;
      assign dscore_in = '0;
      assign dstart_in = base_q;
    end else begin : g_link
      assign fire_in   = fire_w[j-1];
      assign lscore_in = score_w[j-1];
      assign lstart_in = start_w[j-1];
      assign dscore_in = dscore_w[j-1];
      assign dstart_in = dstart_w[j-1];
    end

    apms_cell #(
      .PosW      (POSITION_BITS),
      .InitScore (j + 1)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .init_i       (init_w),
      .fire_i       (fire_in),
      .pat_i        (pat_byte),
      .sym_i        (sym_q),
      .left_score_i (lscore_in),
      .left_start_i (lstart_in),
      .diag_score_i (dscore_in),
      .diag_start_i (dstart_in),
      .fire_o       (fire_w[j]),
      .score_o      (score_w[j]),
      .start_o      (start_w[j]),
      .diag_score_o (dscore_w[j]),
      .diag_start_o (dstart_w[j])
    );
  end

  assign done_w = fire_w[Cap-1];

  // Clamp the pattern length and pick the last cell in use
  logic [SW-1:0]            plen_w;
  logic [IdxW-1:0]          idx_w;
  logic [SW-1:0]            last_score_w;
  logic [POSITION_BITS-1:0] last_start_w;
  logic                     match_w;

  always_comb begin
    if (pat_len_q == '0) begin
      plen_w = SW'(1);
    end else if (pat_len_q > SW'(Cap)) begin
      plen_w = SW'(Cap);
    end else begin
      plen_w = pat_len_q;
    end
  end

  assign idx_w        = IdxW'(plen_w - SW'(1));
  assign last_score_w = score_w[idx_w];
  assign last_start_w = start_w[idx_w];
  assign match_w      = (pos_q >= POSITION_BITS'(plen_w)) && (last_score_w <= dist_lim_q);

  // Step the sequencer
  always_comb begin
    state_d = state_q;
    load_w  = 1'b0;
    case (state_q)
      apms_pkg::S_IDLE: begin
        if (in_accept) state_d = apms_pkg::S_RUN;
      end
      apms_pkg::S_RUN: begin
        if (done_w) begin
          if (out_free) begin
            load_w  = 1'b1;
            state_d = apms_pkg::S_IDLE;
          end else begin
            state_d = apms_pkg::S_HOLD;
          end
        end
      end
      apms_pkg::S_HOLD: begin
        if (out_free) begin
          load_w  = 1'b1;
          state_d = apms_pkg::S_IDLE;
        end
      end
      default: state_d = apms_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= apms_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register
  logic                     out_valid_q;
  logic [31:0]              start_out_q, end_out_q;
  logic [SW-1:0]            dist_out_q;
  logic [POSITION_BITS+31:0] start_ext_w, end_ext_w;

  assign start_ext_w = {32'd0, last_start_w};
  assign end_ext_w   = {32'd0, pos_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_w) begin
      out_valid_q <= match_w;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_w) begin
      start_out_q <= start_ext_w[31:0];
      end_out_q   <= end_ext_w[31:0];
      dist_out_q  <= last_score_w;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign match_start_o   = start_out_q;
  assign match_end_o     = end_out_q;
  assign edit_distance_o = dist_out_q;

`ifndef SYNTHESIS
  // At most one cell holds the wavefront token
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({fire_w, fire0_q}))
    else $error("more than one update token in the cell row");

  // An accepted word starts the wavefront next cycle
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> fire0_q)
    else $error("wavefront did not start");

  // The row finishes only while running
  a_done_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_w |-> (state_q == apms_pkg::S_RUN))
    else $error("row finished outside the run state");

  // Position never steps back within one text
  a_pos_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !text_restart_i) |=> (pos_q >= $past(pos_q)))
    else $error("text position went backward");

  // A new output word comes only from a finished item
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q != apms_pkg::S_IDLE))
    else $error("output word without a finished item");
`endif

endmodule

`default_nettype wire

>>> rtl/apms_cell.sv
`default_nettype none

module apms_cell #(
  parameter int PosW      = 32,
  parameter int InitScore = 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        init_i,
  input  wire logic                        fire_i,
  input  wire logic [apms_pkg::SYM_W-1:0]  pat_i,
  input  wire logic [apms_pkg::SYM_W-1:0]  sym_i,
  input  wire logic [apms_pkg::SCORE_W-1:0] left_score_i,
  input  wire logic [PosW-1:0]             left_start_i,
  input  wire logic [apms_pkg::SCORE_W-1:0] diag_score_i,
  input  wire logic [PosW-1:0]             diag_start_i,
  output logic                             fire_o,
  output logic [apms_pkg::SCORE_W-1:0]     score_o,
  output logic [PosW-1:0]                  start_o,
  output logic [apms_pkg::SCORE_W-1:0]     diag_score_o,
  output logic [PosW-1:0]                  diag_start_o
);

  logic [apms_pkg::SCORE_W-1:0] score_q, score_d;
  logic [PosW-1:0]              start_q, start_d;
  logic                         fire_q;
  logic [apms_pkg::SCORE_W-1:0] diag_score_q;
  logic [PosW-1:0]              diag_start_q;

  logic [apms_pkg::SCORE_W-1:0] del_score, ins_score, sub_score, mid_score;
  logic [PosW-1:0]              mid_start;

  // Pick deletion, then insertion, then substitution; ties go to the earlier start
  always_comb begin
    del_score = score_q + apms_pkg::SCORE_W'(1);
    ins_score = left_score_i + apms_pkg::SCORE_W'(1);
    sub_score = diag_score_i + ((pat_i == sym_i) ? apms_pkg::SCORE_W'(0)
                                                 : apms_pkg::SCORE_W'(1));
    mid_score = del_score;
    mid_start = start_q;
    if ((ins_score < del_score) ||
        ((ins_score == del_score) && (left_start_i < start_q))) begin
      mid_score = ins_score;
      mid_start = left_start_i;
    end
    score_d = mid_score;
    start_d = mid_start;
    if ((sub_score < mid_score) ||
        ((sub_score == mid_score) && (diag_start_i < mid_start))) begin
      score_d = sub_score;
      start_d = diag_start_i;
    end
  end

  // Column entry: clear on new text, update when the wavefront passes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_q <= apms_pkg::SCORE_W'(InitScore);
      start_q <= '0;
    end else if (init_i) begin
      score_q <= apms_pkg::SCORE_W'(InitScore);
      start_q <= '0;
    end else if (fire_i) begin
      score_q <= score_d;
      start_q <= start_d;
    end
  end

  // Hand the token on to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fire_q <= 1'b0;
    end else begin
      fire_q <= fire_i;
    end
  end

  // Keep the old entry as the neighbor's diagonal
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      diag_score_q <= score_q;
      diag_start_q <= start_q;
    end
  end

  assign fire_o       = fire_q;
  assign score_o      = score_q;
  assign start_o      = start_q;
  assign diag_score_o = diag_score_q;
  assign diag_start_o = diag_start_q;

endmodule

`default_nettype wire
